// ----- hw/rtl/bgb_pkg.sv -----
// Shared constants and types for the bilateral grid builder.
// No dependencies; imported by bgb_div, the top level and the testbench.
`default_nettype none

package bgb_pkg;

  localparam int CELLS_PER_BIN = 256;
  localparam int NUM_BINS      = 9;
  localparam int CELL_SHIFT    = 5;
  localparam int STORE_DEPTH   = NUM_BINS * CELLS_PER_BIN;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int LIN_W         = $clog2(CELLS_PER_BIN) + 1;
  localparam int COUNT_W       = 17;
  localparam int SUM_W         = 24;
  localparam int VALUE_W       = 14;
  localparam int GRID_W        = 5;
  localparam int BIN_W         = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(16 * 1023);
  localparam logic [GRID_W-1:0]  GRID_MAX  = GRID_W'(16);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ACCUM  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // divider handshake between sequencer and divide unit
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bgb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bgb_div.sv -----
// Restoring divider, one quotient bit per cycle: sum / count for normalize.
// Depends on bgb_pkg.
`default_nettype none

module bgb_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bgb_pkg::div_req_t             req,
  input  wire logic [bgb_pkg::SUM_W-1:0]     dividend,
  input  wire logic [bgb_pkg::COUNT_W-1:0]   divisor,
  output bgb_pkg::div_rsp_t                  rsp,
  output logic      [bgb_pkg::SUM_W-1:0]     quotient
);
  import bgb_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [COUNT_W:0]   rem;
  logic [COUNT_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W+1:0] diff;

  assign rem_sh = {rem[COUNT_W-1:0], quotient[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start && !busy) begin
        busy     <= 1'b1;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
        cnt      <= CNT_W'(SUM_W);
      end else if (busy) begin
        if (!diff[COUNT_W+1]) begin
          rem      <= diff[COUNT_W:0];
          quotient <= {quotient[SUM_W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh;
          quotient <= {quotient[SUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (!(done && busy))
        else $error("divider done while busy");
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bilateral_grid_builder_core.sv -----
// Bilateral grid builder top level: command sequencer, grid stores, scratch
// stores for the filter passes, and the shared divider for normalize.
// Depends on bgb_pkg, bgb_ram, bgb_div.
//
// Finish makes 3 passes (x, y, bin), each copying the grid stores to the
// scratch stores and then filtering every grid cell; it then normalizes each
// entry, dividing it when its count is nonzero (the divider runs one quotient
// bit per cycle).
// One item at a time; a finished result may wait while the next item runs.
// Reset starts a clearing pass of the count and sum grid stores, not ready meanwhile.
`default_nettype none

module bilateral_grid_builder_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    cmd,
  input  wire logic [13:0]                   pixel_value,
  input  wire logic [8:0]                    pixel_col,
  input  wire logic [8:0]                    pixel_row,
  input  wire logic [3:0]                    read_bin,
  input  wire logic [7:0]                    read_cell,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [13:0]                   cell_value,
  output logic                               status,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [4:0]                    cfg_data
);
  import bgb_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ACC, S_READ, S_COPY, S_FILT, S_NORM, S_DIV, S_DONE
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [BIN_W-1:0]  LAST_BIN = BIN_W'(NUM_BINS - 1);

  state_t              state;
  logic [2:0]          ph;
  logic [ADDR_W-1:0]   idx;
  logic [1:0]          axis;
  logic [BIN_W-1:0]    b;
  logic [GRID_W-1:0]   x;
  logic [GRID_W-1:0]   y;
  logic [LIN_W-1:0]    lin;
  logic                clr_report;
  logic [ADDR_W-1:0]   addr_r;
  logic [VALUE_W-1:0]  val_r;
  logic [VALUE_W-1:0]  res_value;
  logic                res_status;
  logic [GRID_W-1:0]   grid_width;
  logic [GRID_W-1:0]   grid_height;
  logic [COUNT_W-1:0]  cm, cl, cr;
  logic [SUM_W-1:0]    sm, sl, sr;

  // memory ports
  logic [ADDR_W-1:0]   m_raddr, m_waddr, s_raddr, s_waddr;
  logic                m_cwe, m_swe, s_we;
  logic [COUNT_W-1:0]  m_cwdata, m_crdata, s_crdata;
  logic [SUM_W-1:0]    m_swdata, m_srdata, s_srdata;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [SUM_W-1:0]    div_q;

  bgb_ram #(.WIDTH(COUNT_W), .DEPTH(STORE_DEPTH), .AW(ADDR_W)) u_cnt_ram (
    .clk, .we(m_cwe), .waddr(m_waddr), .wdata(m_cwdata), .raddr(m_raddr), .rdata(m_crdata)
  );
  bgb_ram #(.WIDTH(SUM_W), .DEPTH(STORE_DEPTH), .AW(ADDR_W)) u_sum_ram (
    .clk, .we(m_swe), .waddr(m_waddr), .wdata(m_swdata), .raddr(m_raddr), .rdata(m_srdata)
  );
  bgb_ram #(.WIDTH(COUNT_W), .DEPTH(STORE_DEPTH), .AW(ADDR_W)) u_scnt_ram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(m_crdata), .raddr(s_raddr), .rdata(s_crdata)
  );
  bgb_ram #(.WIDTH(SUM_W), .DEPTH(STORE_DEPTH), .AW(ADDR_W)) u_ssum_ram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(m_srdata), .raddr(s_raddr), .rdata(s_srdata)
  );

  bgb_div u_div (
    .clk, .rst, .req(div_req), .dividend(m_srdata), .divisor(m_crdata),
    .rsp(div_rsp), .quotient(div_q)
  );

  function automatic logic [ADDR_W-1:0] addr_of(logic [BIN_W-1:0] bn, logic [LIN_W-1:0] ln);
    addr_of = ADDR_W'(ADDR_W'(bn) * ADDR_W'(CELLS_PER_BIN)) + ADDR_W'(ln);
  endfunction

  // ---- accept-time decode
  logic [9:0]          col_sum, row_sum;
  logic [GRID_W-1:0]   cx, cy;
  logic [BIN_W-1:0]    acc_bin;
  logic [9:0]          acc_lin;
  logic [9:0]          grid_cells;
  logic                acc_ok, rd_ok;

  always_comb begin
    col_sum    = {1'b0, pixel_col} + 10'(1 << (CELL_SHIFT - 1));
    row_sum    = {1'b0, pixel_row} + 10'(1 << (CELL_SHIFT - 1));
    cx         = GRID_W'(col_sum >> CELL_SHIFT);
    cy         = GRID_W'(row_sum >> CELL_SHIFT);
    acc_bin    = BIN_W'((15'(pixel_value) + 15'd1024) >> 11);
    acc_lin    = 10'(cy * grid_width) + 10'(cx);
    grid_cells = 10'(grid_width * grid_height);
    acc_ok     = (acc_bin < BIN_W'(NUM_BINS)) && (cx < grid_width) && (cy < grid_height)
                 && (acc_lin < 10'(CELLS_PER_BIN));
    rd_ok      = (read_bin < BIN_W'(NUM_BINS)) && (10'(read_cell) < grid_cells)
                 && (10'(read_cell) < 10'(CELLS_PER_BIN));
  end

  // ---- filter neighbors
  logic                cell_live, l_ok, r_ok;
  logic [ADDR_W-1:0]   m_addr, l_addr, r_addr;
  logic [LIN_W-1:0]    lin_p1, lin_pw;
  logic [COUNT_W+1:0]  cnt_f;
  logic [COUNT_W-1:0]  cnt_sat;
  logic [SUM_W-1:0]    sum_f;

  always_comb begin
    cell_live = (grid_width != '0) && (y < grid_height) && (lin < LIN_W'(CELLS_PER_BIN));
    lin_p1    = lin + LIN_W'(1);
    lin_pw    = lin + LIN_W'(grid_width);
    m_addr    = addr_of(b, lin);
    l_addr    = m_addr;
    r_addr    = m_addr;
    l_ok      = 1'b0;
    r_ok      = 1'b0;
    case (axis)
      2'd0: begin
        l_ok   = x != '0;
        r_ok   = (x + GRID_W'(1) < grid_width) && (lin_p1 < LIN_W'(CELLS_PER_BIN));
        l_addr = addr_of(b, lin - LIN_W'(1));
        r_addr = addr_of(b, lin_p1);
      end
      2'd1: begin
        l_ok   = y != '0;
        r_ok   = (y + GRID_W'(1) < grid_height) && (lin_pw < LIN_W'(CELLS_PER_BIN));
        l_addr = addr_of(b, lin - LIN_W'(grid_width));
        r_addr = addr_of(b, lin_pw);
      end
      default: begin
        l_ok   = b != '0;
        r_ok   = b != LAST_BIN;
        l_addr = addr_of(b - BIN_W'(1), lin);
        r_addr = addr_of(b + BIN_W'(1), lin);
      end
    endcase
    cnt_f   = {2'b00, cl} + {1'b0, cm, 1'b0} + {2'b00, cr};
    cnt_sat = (cnt_f > {2'b00, COUNT_MAX}) ? COUNT_MAX : cnt_f[COUNT_W-1:0];
    sum_f   = SUM_W'((sl >> 2) + (sm >> 1) + (sr >> 2));
  end

  // ---- accumulate update
  logic [COUNT_W-1:0]  acc_cnt;
  logic [SUM_W:0]      acc_sum_w;
  logic [SUM_W-1:0]    acc_sum;
  logic [COUNT_W-1:0]  rd_sat;
  logic [VALUE_W-1:0]  q_sat;

  always_comb begin
    acc_cnt   = (m_crdata < COUNT_MAX) ? m_crdata + COUNT_W'(1) : m_crdata;
    acc_sum_w = {1'b0, m_srdata} + (SUM_W+1)'(val_r);
    acc_sum   = (acc_sum_w > {1'b0, SUM_MAX}) ? SUM_MAX : acc_sum_w[SUM_W-1:0];
    rd_sat    = (m_crdata > COUNT_W'(VALUE_MAX)) ? COUNT_W'(VALUE_MAX) : m_crdata;
    q_sat     = (div_q > SUM_W'(VALUE_MAX)) ? VALUE_MAX : div_q[VALUE_W-1:0];
  end

  // ---- memory control
  always_comb begin
    m_raddr  = (state == S_ACC || state == S_READ) ? addr_r : idx;
    m_waddr  = idx;
    m_cwe    = 1'b0;
    m_swe    = 1'b0;
    m_cwdata = '0;
    m_swdata = '0;
    s_we     = 1'b0;
    s_waddr  = idx;
    div_req.start = 1'b0;
    unique case (ph)
      3'd0:    s_raddr = m_addr;
      3'd1:    s_raddr = l_addr;
      default: s_raddr = r_addr;
    endcase
    unique case (state)
      S_CLEAR: begin
        m_cwe = 1'b1;
        m_swe = 1'b1;
      end
      S_ACC: if (ph == 3'd1) begin
        m_cwe    = 1'b1;
        m_swe    = 1'b1;
        m_waddr  = addr_r;
        m_cwdata = acc_cnt;
        m_swdata = acc_sum;
      end
      S_COPY: s_we = ph == 3'd1;
      S_FILT: if (ph == 3'd4) begin
        m_cwe    = 1'b1;
        m_swe    = 1'b1;
        m_waddr  = m_addr;
        m_cwdata = cnt_sat;
        m_swdata = sum_f;
      end
      S_NORM: if (ph == 3'd1) begin
        if (m_crdata == '0) begin
          m_cwe = 1'b1;
        end else begin
          div_req.start = 1'b1;
        end
      end
      S_DIV: if (div_rsp.done) begin
        m_cwe    = 1'b1;
        m_cwdata = COUNT_W'(q_sat);
      end
      default: ;
    endcase
  end

  assign in_ready = state == S_IDLE;

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      ph         <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
      grid_width <= GRID_MAX;
      grid_height <= GRID_MAX;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_WIDTH) begin
          grid_width <= (cfg_data > GRID_MAX) ? GRID_MAX : cfg_data;
        end else begin
          grid_height <= (cfg_data > GRID_MAX) ? GRID_MAX : cfg_data;
        end
      end
      // S_DONE reloads the result register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          res_value  <= '0;
          res_status <= 1'b0;
          val_r      <= pixel_value;
          idx        <= '0;
          ph         <= '0;
          unique case (cmd_t'(cmd))
            CMD_CLEAR: begin
              clr_report <= 1'b1;
              state      <= S_CLEAR;
            end
            CMD_ACCUM: begin
              addr_r <= addr_of(acc_bin, LIN_W'(acc_lin));
              if (acc_ok) begin
                state <= S_ACC;
              end else begin
                res_status <= 1'b1;
                state      <= S_DONE;
              end
            end
            CMD_FINISH: begin
              axis  <= 2'd0;
              state <= S_COPY;
            end
            CMD_READ: begin
              addr_r <= addr_of(read_bin, LIN_W'(read_cell));
              if (rd_ok) begin
                state <= S_READ;
              end else begin
                res_status <= 1'b1;
                state      <= S_DONE;
              end
            end
          endcase
        end
        S_CLEAR: begin
          idx <= idx + ADDR_W'(1);
          if (idx == LAST_IDX) begin
            state <= clr_report ? S_DONE : S_IDLE;
          end
        end
        S_ACC: begin
          ph <= ph + 3'd1;
          if (ph == 3'd1) state <= S_DONE;
        end
        S_READ: begin
          ph <= ph + 3'd1;
          if (ph == 3'd1) begin
            res_value <= rd_sat[VALUE_W-1:0];
            state     <= S_DONE;
          end
        end
        S_COPY: begin
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else begin
            ph  <= 3'd0;
            idx <= idx + ADDR_W'(1);
            if (idx == LAST_IDX) begin
              state <= S_FILT;
              b     <= '0;
              x     <= '0;
              y     <= '0;
              lin   <= '0;
            end
          end
        end
        S_FILT: begin
          unique case (ph)
            3'd0: begin
              if (cell_live) begin
                ph <= 3'd1;
              end else begin
                x   <= '0;
                y   <= '0;
                lin <= '0;
                b   <= b + BIN_W'(1);
                if (b == LAST_BIN) begin
                  idx <= '0;
                  if (axis == 2'd2) begin
                    state <= S_NORM;
                  end else begin
                    axis  <= axis + 2'd1;
                    state <= S_COPY;
                  end
                end
              end
            end
            3'd1: begin
              cm <= s_crdata;
              sm <= s_srdata;
              ph <= 3'd2;
            end
            3'd2: begin
              cl <= l_ok ? s_crdata : '0;
              sl <= l_ok ? s_srdata : '0;
              ph <= 3'd3;
            end
            3'd3: begin
              cr <= r_ok ? s_crdata : '0;
              sr <= r_ok ? s_srdata : '0;
              ph <= 3'd4;
            end
            default: begin
              ph  <= 3'd0;
              lin <= lin_p1;
              if (x + GRID_W'(1) == grid_width) begin
                x <= '0;
                y <= y + GRID_W'(1);
              end else begin
                x <= x + GRID_W'(1);
              end
            end
          endcase
        end
        S_NORM: begin
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else begin
            ph <= 3'd0;
            if (m_crdata != '0) begin
              state <= S_DIV;
            end else begin
              idx <= idx + ADDR_W'(1);
              if (idx == LAST_IDX) state <= S_DONE;
            end
          end
        end
        S_DIV: if (div_rsp.done) begin
          idx   <= idx + ADDR_W'(1);
          state <= (idx == LAST_IDX) ? S_DONE : S_NORM;
        end
        S_DONE: if (!out_valid || out_ready) begin
          out_valid  <= 1'b1;
          cell_value <= res_value;
          status     <= res_status;
          clr_report <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- checks
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (cell_value == '0))
    else $error("flagged item carries a value");

  a_value_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cell_value <= VALUE_MAX))
    else $error("result above saturation limit");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside normalize");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> (state == S_DIV && div_rsp.busy))
    else $error("divider not running after start");

endmodule

`default_nettype wire

// ----- verif/bilateral_grid_builder_core_tb.sv -----
// Self-checking testbench for bilateral_grid_builder_core: random and directed
// commands with a cycle-free predictor of the grid stores. Depends on bgb_pkg.
`default_nettype none

module bilateral_grid_builder_core_tb;
  import bgb_pkg::*;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               flag;
  } grid_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          cmd = CMD_CLEAR;
  logic [13:0]         pixel_value = '0;
  logic [8:0]          pixel_col = '0;
  logic [8:0]          pixel_row = '0;
  logic [3:0]          read_bin = '0;
  logic [7:0]          read_cell = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [13:0]         cell_value;
  logic                status;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_GRID_WIDTH;
  logic [4:0]          cfg_data = '0;

  bilateral_grid_builder_core dut (.*);

  always #10 clk = ~clk;

  // predicted store contents and grid size
  int unsigned  count_mem [STORE_DEPTH];
  int unsigned  sum_mem   [STORE_DEPTH];
  int unsigned  prev_mem  [STORE_DEPTH];
  int unsigned  cells_x = 16;
  int unsigned  cells_y = 16;
  grid_result_t pending_q [$];
  int           errors = 0;
  bit           steady = 1'b0;     // no idling on either side
  bit           hold_req = 1'b0;   // ask the receiver for a long hold-off
  int           stall_left = 0;

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit cell_in_grid(input int x, input int y);
    if (x < 0 || y < 0 || x >= int'(cells_x) || y >= int'(cells_y)) return 1'b0;
    return y * int'(cells_x) + x < CELLS_PER_BIN;
  endfunction

  function automatic int unsigned prev_tap(input int b, input int x, input int y);
    if (b < 0 || b >= NUM_BINS || !cell_in_grid(x, y)) return 0;
    return prev_mem[b * CELLS_PER_BIN + y * int'(cells_x) + x];
  endfunction

  // zero-padded 1-2-1 along one axis (0 x, 1 y, 2 bin); sums use quarter-half-quarter taps
  function automatic void smooth(input bit on_sums, input int axis);
    int unsigned l, m, r, v;
    prev_mem = on_sums ? sum_mem : count_mem;
    for (int b = 0; b < NUM_BINS; b++)
      for (int y = 0; y < int'(cells_y); y++)
        for (int x = 0; x < int'(cells_x); x++) begin
          if (!cell_in_grid(x, y)) continue;
          m = prev_tap(b, x, y);
          case (axis)
            0: begin l = prev_tap(b, x - 1, y); r = prev_tap(b, x + 1, y); end
            1: begin l = prev_tap(b, x, y - 1); r = prev_tap(b, x, y + 1); end
            default: begin l = prev_tap(b - 1, x, y); r = prev_tap(b + 1, x, y); end
          endcase
          if (on_sums) begin
            v = (l >> 2) + (m >> 1) + (r >> 2);
            sum_mem[b * CELLS_PER_BIN + y * int'(cells_x) + x] = v;
          end else begin
            v = l + 2 * m + r;
            if (v > COUNT_MAX) v = COUNT_MAX;
            count_mem[b * CELLS_PER_BIN + y * int'(cells_x) + x] = v;
          end
        end
  endfunction

  function automatic grid_result_t grid_step(input cmd_t c, input int unsigned val,
      input int unsigned col, input int unsigned row, input int unsigned rbin,
      input int unsigned rcell);
    grid_result_t res;
    int unsigned  bin, k, q;
    int           cx, cy;
    res.value = '0;
    res.flag  = 1'b0;
    case (c)
      CMD_CLEAR: begin
        foreach (count_mem[i]) begin count_mem[i] = 0; sum_mem[i] = 0; end
      end
      CMD_ACCUM: begin
        bin = (val + 1024) >> 11;
        cx  = (col + 16) >> CELL_SHIFT;
        cy  = (row + 16) >> CELL_SHIFT;
        if (bin >= NUM_BINS || !cell_in_grid(cx, cy)) res.flag = 1'b1;
        else begin
          k = bin * CELLS_PER_BIN + cy * cells_x + cx;
          if (count_mem[k] < COUNT_MAX) count_mem[k]++;
          sum_mem[k] += val;
          if (sum_mem[k] > SUM_MAX) sum_mem[k] = SUM_MAX;
        end
      end
      CMD_FINISH: begin
        for (int a = 0; a < 3; a++) begin smooth(1'b0, a); smooth(1'b1, a); end
        foreach (count_mem[i]) begin
          q = (count_mem[i] != 0) ? sum_mem[i] / count_mem[i] : 0;
          count_mem[i] = (q > VALUE_MAX) ? VALUE_MAX : q;
        end
      end
      default: begin
        if (rbin >= NUM_BINS || rcell >= cells_x * cells_y || rcell >= CELLS_PER_BIN)
          res.flag = 1'b1;
        else begin
          q = count_mem[rbin * CELLS_PER_BIN + rcell];
          res.value = (q > VALUE_MAX) ? VALUE_MAX : VALUE_W'(q);
        end
      end
    endcase
    return res;
  endfunction

  task automatic send_item(input cmd_t c, input int unsigned val, input int unsigned col,
      input int unsigned row, input int unsigned rbin, input int unsigned rcell);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    pixel_value <= 14'(val);
    pixel_col   <= 9'(col);
    pixel_row   <= 9'(row);
    read_bin    <= 4'(rbin);
    read_cell   <= 8'(rcell);
    // ready is settled by the falling edge; the next rising edge accepts
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    pending_q.push_back(grid_step(c, val, col, row, rbin, rcell));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] data);
    int unsigned v;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    v = (data > 16) ? 16 : data;
    if (idx == CFG_GRID_WIDTH) cells_x = v;
    else cells_y = v;
  endtask

  // accumulate landing in a valid cell, coordinates spread over the rounding window
  task automatic accum_in_grid();
    int cx, cy, lo_x, lo_y;
    do begin
      cx = $urandom_range(0, cells_x - 1);
      cy = $urandom_range(0, cells_y - 1);
    end while (cy * int'(cells_x) + cx >= CELLS_PER_BIN);
    lo_x = (cx == 0) ? 0 : cx * 32 - 16;
    lo_y = (cy == 0) ? 0 : cy * 32 - 16;
    send_item(CMD_ACCUM, $urandom_range(0, 16383),
              $urandom_range(lo_x, (cx * 32 + 15 > 511) ? 511 : cx * 32 + 15),
              $urandom_range(lo_y, (cy * 32 + 15 > 511) ? 511 : cy * 32 + 15),
              $urandom_range(0, 15), $urandom_range(0, 255));
  endtask

  task automatic read_in_grid();
    send_item(CMD_READ, $urandom_range(0, 16383), $urandom_range(0, 511),
              $urandom_range(0, 511), $urandom_range(0, NUM_BINS - 1),
              $urandom_range(0, cells_x * cells_y - 1));
  endtask

  task automatic noise_item(input bit allow_clear);
    cmd_t c;
    c = ($urandom_range(0, 1) != 0) ? CMD_ACCUM : CMD_READ;
    if (allow_clear && $urandom_range(0, 49) == 0) c = CMD_CLEAR;
    send_item(c, $urandom_range(0, 16383), $urandom_range(0, 511),
              $urandom_range(0, 511), $urandom_range(0, 15), $urandom_range(0, 255));
  endtask

  task automatic test_directed();
    send_item(CMD_READ, 0, 0, 0, 0, 0);            // read before any data
    send_item(CMD_ACCUM, 0, 0, 0, 0, 0);
    send_item(CMD_ACCUM, 16383, 15, 15, 0, 0);     // top bin, rounds to cell 0
    send_item(CMD_ACCUM, 1023, 16, 16, 0, 0);      // rounds up to cell (1,1)
    send_item(CMD_ACCUM, 1024, 495, 495, 0, 0);    // last cell of 16x16
    send_item(CMD_ACCUM, 5000, 496, 0, 0, 0);      // column off the grid
    send_item(CMD_ACCUM, 5000, 0, 511, 0, 0);      // row off the grid
    send_item(CMD_ACCUM, 16383, 511, 511, 15, 255);
    send_item(CMD_READ, 0, 0, 0, 8, 0);
    send_item(CMD_READ, 0, 0, 0, 0, 17);
    send_item(CMD_READ, 0, 0, 0, 8, 255);
    send_item(CMD_READ, 0, 0, 0, 9, 0);            // bin beyond grid
    send_item(CMD_READ, 0, 0, 0, 15, 255);
    send_item(CMD_FINISH, 0, 0, 0, 0, 0);
    send_item(CMD_READ, 0, 0, 0, 4, 0);
    send_item(CMD_READ, 0, 0, 0, 0, 0);
    send_item(CMD_READ, 0, 0, 0, 5, 255);
    send_item(CMD_ACCUM, 8191, 40, 70, 0, 0);      // accumulate after finish
    send_item(CMD_READ, 0, 0, 0, 4, 33);
    send_item(CMD_CLEAR, 16383, 511, 511, 15, 255);
    send_item(CMD_READ, 0, 0, 0, 8, 0);
    drain();
  endtask

  task automatic test_grid_sizes();
    // zero width: no cells at all
    write_reg(CFG_GRID_WIDTH, 5'd0);
    repeat (6) accum_in_grid_or_any();
    drain();
    write_reg(CFG_GRID_WIDTH, 5'd31);              // saturates to 16
    write_reg(CFG_GRID_HEIGHT, 5'd1);
    repeat (20) accum_in_grid();
    repeat (4) noise_item(1'b0);
    send_item(CMD_FINISH, 0, 0, 0, 0, 0);
    repeat (10) read_in_grid();
    drain();
    write_reg(CFG_GRID_WIDTH, 5'd1);
    write_reg(CFG_GRID_HEIGHT, 5'd17);             // saturates to 16
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
    repeat (20) accum_in_grid();
    send_item(CMD_FINISH, 0, 0, 0, 0, 0);
    repeat (10) read_in_grid();
    repeat (4) noise_item(1'b0);
    drain();
  endtask

  task automatic accum_in_grid_or_any();
    if ($urandom_range(0, 1) != 0) noise_item(1'b0);
    else send_item(CMD_READ, 0, 0, 0, $urandom_range(0, 8), $urandom_range(0, 255));
  endtask

  task automatic test_random();
    int unsigned sizes [4][2] = '{'{16, 16}, '{5, 7}, '{3, 16}, '{16, 11}};
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_GRID_WIDTH, 5'(sizes[p][0]));
      write_reg(CFG_GRID_HEIGHT, 5'(sizes[p][1]));
      send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
      steady = (p == 2);
      for (int i = 0; i < 190; i++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) accum_in_grid();
        else if (r < 85) read_in_grid();
        else noise_item(1'b1);
        if (i == 150) send_item(CMD_FINISH, 0, 0, 0, 0, 0);
      end
      steady = 1'b0;
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1) != 0) accum_in_grid();
      else read_in_grid();
    end
    drain();
  endtask

  // receiver: random stalls, and one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      stall_left = 300;
      hold_req   = 1'b0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready  <= 1'b1;
      stall_left = gap_len();
    end
  end

  // result is stable from the falling edge until the accepting rising edge
  always @(negedge clk) begin
    grid_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) report("result with none expected");
      else begin
        exp_res = pending_q.pop_front();
        if (cell_value !== exp_res.value)
          report($sformatf("cell_value %0d, expected %0d", cell_value, exp_res.value));
        if (status !== exp_res.flag)
          report($sformatf("status %0b, expected %0b", status, exp_res.flag));
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    foreach (count_mem[i]) begin count_mem[i] = 0; sum_mem[i] = 0; end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_grid_sizes();
    test_random();
    test_backpressure();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
